/* hw/rtl/cvls_pkg.sv */
// ----------------------------------------------------------------------------
// cvls_pkg
// Shared types, codes and constants of the composite video line scan-out.
// ----------------------------------------------------------------------------
package cvls_pkg;

  // Default geometry of the frame store and pixel timing.
  localparam int DEF_COLUMNS          = 40;
  localparam int DEF_ROWS             = 24;
  localparam int DEF_ROW_HEIGHT_SHIFT = 3;
  localparam int DEF_PIXEL_UNITS      = 4;

  // Field widths fixed by the item formats.
  localparam int LVL_W  = 3;
  localparam int DUR_W  = 7;
  localparam int LINE_W = 9;
  localparam int COL_W  = 6;
  localparam int ROW_W  = 5;
  localparam int CFG_IDX_W = 3;

  // Multiplexer level codes.
  localparam logic [LVL_W-1:0] LVL_BLACK = 3'd0;
  localparam logic [LVL_W-1:0] LVL_BURST = 3'd6;
  localparam logic [LVL_W-1:0] LVL_ZERO  = 3'd7;

  // Segment durations in nop units.
  localparam logic [DUR_W-1:0] DUR_HOLD  = 7'd0;
  localparam logic [DUR_W-1:0] DUR_SHORT = 7'd16;
  localparam logic [DUR_W-1:0] DUR_MID   = 7'd32;
  localparam logic [DUR_W-1:0] DUR_LONG  = 7'd64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VSYNC_FIRST    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VSYNC_END      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_AFTER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_BEFORE = 3'd4;

  // Input function codes.
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_LINE  = 1'b1;

  typedef struct packed {
    logic [LVL_W-1:0] lvl;
    logic [DUR_W-1:0] dur;
  } seg_t;

  // The four sync segments that open every line.
  function automatic seg_t sync_seg(input logic vsync, input logic [1:0] idx);
    seg_t s;
    s.lvl = LVL_BLACK;
    s.dur = DUR_HOLD;
    if (vsync) begin
      unique case (idx)
        2'd0: begin s.lvl = LVL_BLACK; s.dur = DUR_LONG;  end
        2'd1: begin s.lvl = LVL_ZERO;  s.dur = DUR_SHORT; end
        2'd2: begin s.lvl = LVL_ZERO;  s.dur = DUR_MID;   end
        default: begin s.lvl = LVL_ZERO; s.dur = DUR_SHORT; end
      endcase
    end else begin
      unique case (idx)
        2'd0: begin s.lvl = LVL_ZERO;  s.dur = DUR_LONG;  end
        2'd1: begin s.lvl = LVL_BLACK; s.dur = DUR_SHORT; end
        2'd2: begin s.lvl = LVL_BURST; s.dur = DUR_MID;   end
        default: begin s.lvl = LVL_BLACK; s.dur = DUR_HOLD; end
      endcase
    end
    return s;
  endfunction

endpackage

/* hw/rtl/cvls_in_if.sv */
// ----------------------------------------------------------------------------
// cvls_in_if
// Input channel: pixel writes and line events with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cvls_in_if
  import cvls_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             func;
  logic [COL_W-1:0] pixel_column;
  logic [ROW_W-1:0] pixel_row;
  logic [LVL_W-1:0] pixel_color;

  modport source (output valid, func, pixel_column, pixel_row, pixel_color, input ready);
  modport sink   (input valid, func, pixel_column, pixel_row, pixel_color, output ready);
endinterface

/* hw/rtl/cvls_out_if.sv */
// ----------------------------------------------------------------------------
// cvls_out_if
// Output channel: one video segment per item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cvls_out_if
  import cvls_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] level_code;
  logic [DUR_W-1:0] duration_units;
  logic             last_segment;

  modport source (output valid, level_code, duration_units, last_segment, input ready);
  modport sink   (input valid, level_code, duration_units, last_segment, output ready);
endinterface

/* hw/rtl/cvls_frame_mem.sv */
// ----------------------------------------------------------------------------
// cvls_frame_mem
// Frame store: one write and one registered read port, cleared after reset.
// ----------------------------------------------------------------------------
module cvls_frame_mem
  import cvls_pkg::*;
#(
  parameter int DEPTH = DEF_COLUMNS * DEF_ROWS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [LVL_W-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [LVL_W-1:0] rd_data_o,
  output logic             busy_o
);

  logic [LVL_W-1:0] mem [DEPTH];
  logic             clr_busy_q, clr_busy_d;
  logic [AW-1:0]    clr_idx_q, clr_idx_d;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [LVL_W-1:0] wdata;

  // The clearing pass owns the write port until every entry is black.
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_idx_d  = clr_idx_q;
    if (clr_busy_q) begin
      if (clr_idx_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_idx_d = clr_idx_q + AW'(1);
      end
    end
    we    = clr_busy_q | wr_en_i;
    waddr = clr_busy_q ? clr_idx_q : wr_addr_i;
    wdata = clr_busy_q ? LVL_BLACK : wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_idx_q  <= clr_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

  assign busy_o = clr_busy_q;

endmodule

/* hw/rtl/composite_video_line_scanout_top.sv */
// ----------------------------------------------------------------------------
// composite_video_line_scanout_top
// A line event is accepted in ST_IDLE, then passes ST_PREP; ST_RUN issues
// its segments to stage one and on to the output register. Throughput: one
// segment per cycle while out_o.ready holds; a line event gives 4 segments,
// or COLUMNS+5 on visible lines. The segment sequencer sets the pace, reading
// one store entry a cycle unless stalled. Reset: counter 0, registers to
// defaults; a clearing pass blackens the store while no item is accepted.
// ----------------------------------------------------------------------------
module composite_video_line_scanout_top
  import cvls_pkg::*;
#(
  parameter int COLUMNS          = DEF_COLUMNS,
  parameter int ROWS             = DEF_ROWS,
  parameter int ROW_HEIGHT_SHIFT = DEF_ROW_HEIGHT_SHIFT,
  parameter int PIXEL_UNITS      = DEF_PIXEL_UNITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cvls_in_if.sink              in_i,
  cvls_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LINE_W-1:0]    cfg_wdata_i
);

  // Store geometry: entry address is row * COLUMNS + column.
  localparam int DEPTH = COLUMNS * ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  // Segment index covers the four sync segments, the pixels and the hold.
  localparam int SEG_W = $clog2(COLUMNS + 5);
  localparam logic [SEG_W-1:0] SEG_SYNC_LAST = SEG_W'(3);
  localparam logic [SEG_W-1:0] SEG_PIX_FIRST = SEG_W'(4);
  localparam logic [SEG_W-1:0] SEG_HOLD      = SEG_W'(COLUMNS + 4);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  // Configuration registers.
  logic [LINE_W-1:0] vsync_first_q, vsync_end_q, wrap_q, vis_after_q, vis_before_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsync_first_q <= 9'd248;
      vsync_end_q   <= 9'd251;
      wrap_q        <= 9'd263;
      vis_after_q   <= 9'd30;
      vis_before_q  <= 9'd220;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_VSYNC_FIRST:    vsync_first_q <= cfg_wdata_i;
        CFG_VSYNC_END:      vsync_end_q   <= cfg_wdata_i;
        CFG_WRAP:           wrap_q        <= cfg_wdata_i;
        CFG_VISIBLE_AFTER:  vis_after_q   <= cfg_wdata_i;
        CFG_VISIBLE_BEFORE: vis_before_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Control state.
  logic [1:0]        state_q, state_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic              vsync_q, vsync_d;
  logic              vis_q, vis_d;
  logic [RW-1:0]     row_q, row_d;
  logic [SEG_W-1:0]  seg_q, seg_d;
  logic [AW-1:0]     addr_q, addr_d;

  // Stage one holds the segment whose store read is in flight, the output
  // register holds the segment offered downstream.
  logic              s1_valid_q, s1_valid_d;
  logic              s1_mem_q, s1_mem_d;
  logic [LVL_W-1:0]  s1_lvl_q, s1_lvl_d;
  logic [DUR_W-1:0]  s1_dur_q, s1_dur_d;
  logic              s1_last_q, s1_last_d;
  logic              out_valid_q, out_valid_d;
  logic [LVL_W-1:0]  out_lvl_q, out_lvl_d;
  logic [DUR_W-1:0]  out_dur_q, out_dur_d;
  logic              out_last_q, out_last_d;

  // Handshake and store port signals.
  logic              clr_busy;
  logic              in_accept;
  logic              advance;
  logic              issue;
  logic              pix_seg;
  logic              last_seg;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [LVL_W-1:0]  rd_data;
  logic [LINE_W-1:0] line_inc;
  logic [LINE_W-1:0] row_diff;
  logic [LINE_W-1:0] row_shift;
  seg_t              sync;

  assign in_i.ready = (state_q == ST_IDLE) && !clr_busy;
  assign in_accept  = in_i.valid && in_i.ready;

  // A pixel write outside the store is dropped.
  assign wr_en = in_accept && (in_i.func == FUNC_PIXEL)
              && ({1'b0, in_i.pixel_column} < 7'(COLUMNS))
              && ({2'b00, in_i.pixel_row} < 7'(ROWS));
  assign wr_addr = AW'(32'(in_i.pixel_row) * 32'(COLUMNS) + 32'(in_i.pixel_column));

  // Output register frees up when empty or taken; stage one may refill
  // whenever its current segment moves on.
  assign advance  = !out_valid_q || out_o.ready;
  assign issue    = (state_q == ST_RUN) && (!s1_valid_q || advance);
  assign pix_seg  = vis_q && (seg_q >= SEG_PIX_FIRST) && (seg_q < SEG_HOLD);
  assign last_seg = vis_q ? (seg_q == SEG_HOLD) : (seg_q == SEG_SYNC_LAST);
  assign rd_en    = issue && pix_seg;
  assign sync     = sync_seg(vsync_q, seg_q[1:0]);

  assign line_inc  = line_q + 9'd1;
  assign row_diff  = line_q - vis_after_q;
  assign row_shift = row_diff >> ROW_HEIGHT_SHIFT;

  always_comb begin
    state_d = state_q;
    line_d  = line_q;
    vsync_d = vsync_q;
    vis_d   = vis_q;
    row_d   = row_q;
    seg_d   = seg_q;
    addr_d  = addr_q;

    unique case (state_q)
      ST_IDLE: begin
        // The sync pattern follows the stepped count, before the wrap.
        if (in_accept && (in_i.func == FUNC_LINE)) begin
          vsync_d = (line_inc >= vsync_first_q) && (line_inc < vsync_end_q);
          line_d  = (line_inc == wrap_q) ? 9'd1 : line_inc;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        // Visibility and row come from the count after the wrap.
        vis_d = (line_q > vis_after_q) && (line_q < vis_before_q);
        row_d = (row_shift > 9'(ROWS - 1)) ? RW'(ROWS - 1) : row_shift[RW-1:0];
        seg_d = '0;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (seg_q < SEG_PIX_FIRST) begin
          addr_d = AW'(32'(row_q) * 32'(COLUMNS));
        end else if (rd_en) begin
          addr_d = addr_q + AW'(1);
        end
        if (issue) begin
          seg_d = seg_q + SEG_W'(1);
          if (last_seg) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_mem_d   = s1_mem_q;
    s1_lvl_d   = s1_lvl_q;
    s1_dur_d   = s1_dur_q;
    s1_last_d  = s1_last_q;
    if (issue) begin
      s1_valid_d = 1'b1;
      s1_mem_d   = pix_seg;
      s1_last_d  = last_seg;
      if (seg_q < SEG_PIX_FIRST) begin
        s1_lvl_d = sync.lvl;
        s1_dur_d = sync.dur;
      end else if (pix_seg) begin
        s1_lvl_d = LVL_BLACK;
        s1_dur_d = DUR_W'(PIXEL_UNITS);
      end else begin
        s1_lvl_d = LVL_BLACK;
        s1_dur_d = DUR_HOLD;
      end
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    out_lvl_d   = out_lvl_q;
    out_dur_d   = out_dur_q;
    out_last_d  = out_last_q;
    if (advance) begin
      out_valid_d = s1_valid_q;
      out_lvl_d   = s1_mem_q ? rd_data : s1_lvl_q;
      out_dur_d   = s1_dur_q;
      out_last_d  = s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      line_q      <= '0;
      vsync_q     <= 1'b0;
      vis_q       <= 1'b0;
      seg_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      line_q      <= line_d;
      vsync_q     <= vsync_d;
      vis_q       <= vis_d;
      seg_q       <= seg_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q      <= row_d;
    addr_q     <= addr_d;
    s1_mem_q   <= s1_mem_d;
    s1_lvl_q   <= s1_lvl_d;
    s1_dur_q   <= s1_dur_d;
    s1_last_q  <= s1_last_d;
    out_lvl_q  <= out_lvl_d;
    out_dur_q  <= out_dur_d;
    out_last_q <= out_last_d;
  end

  cvls_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_frame_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (in_i.pixel_color),
    .rd_en_i   (rd_en),
    .rd_addr_i (addr_q),
    .rd_data_o (rd_data),
    .busy_o    (clr_busy)
  );

  assign out_o.valid          = out_valid_q;
  assign out_o.level_code     = out_lvl_q;
  assign out_o.duration_units = out_dur_q;
  assign out_o.last_segment   = out_last_q;

  // A new segment never overwrites one in stage one that has not moved on.
  a_no_s1_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && s1_valid_q |-> advance)
    else $error("stage one overwritten before its segment moved on");

  // Store reads happen only for pixel segments of a visible line.
  a_read_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (state_q == ST_RUN) && vis_q && !clr_busy)
    else $error("frame store read outside a visible line");

  // No item is taken while a line run is still being issued.
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_IDLE) || (state_q == ST_PREP) && !$past(rd_en))
    else $error("item accepted during a line run");

endmodule
